// ===== rtl/stp_pkg.sv =====
// Shared types, codes and helpers for the sphere-trace pixel block.
// Used by stp_datapath, stp_ctrl and sphere_trace_pixel; depends on nothing.
package stp_pkg;

  localparam int unsigned MAX_STEPS_DEF = 255;
  localparam int unsigned START_DEF     = 0;
  localparam int unsigned EPS_DEF       = 66;

  // configuration register indexes
  localparam logic [3:0] REG_FRAME_W = 4'd0;
  localparam logic [3:0] REG_FRAME_H = 4'd1;
  localparam logic [3:0] REG_EYE_X   = 4'd2;
  localparam logic [3:0] REG_EYE_Y   = 4'd3;
  localparam logic [3:0] REG_EYE_Z   = 4'd4;
  localparam logic [3:0] REG_FOCAL   = 4'd5;
  localparam logic [3:0] REG_RADIUS  = 4'd6;
  localparam logic [3:0] REG_FAR     = 4'd7;

  // datapath operations
  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_LOAD_RAY  = 5'd1;
  localparam logic [4:0] OP_SQ_FIRST  = 5'd2;
  localparam logic [4:0] OP_SQ        = 5'd3;
  localparam logic [4:0] OP_ACC       = 5'd4;
  localparam logic [4:0] OP_SQRT      = 5'd5;
  localparam logic [4:0] OP_DIV_DIR   = 5'd6;
  localparam logic [4:0] OP_DIV_NRM   = 5'd7;
  localparam logic [4:0] OP_STORE_DIR = 5'd8;
  localparam logic [4:0] OP_STORE_NRM = 5'd9;
  localparam logic [4:0] OP_INIT      = 5'd10;
  localparam logic [4:0] OP_MUL       = 5'd11;
  localparam logic [4:0] OP_PT        = 5'd12;
  localparam logic [4:0] OP_STEP      = 5'd13;
  localparam logic [4:0] OP_CLAMP     = 5'd14;
  localparam logic [4:0] OP_SET_MISS  = 5'd15;
  localparam logic [4:0] OP_SET_HIT   = 5'd16;
  localparam logic [4:0] OP_Q_HI      = 5'd17;
  localparam logic [4:0] OP_Q_LO      = 5'd18;
  localparam logic [4:0] OP_SAVE_HI   = 5'd19;
  localparam logic [4:0] OP_SAVE_D    = 5'd20;
  localparam logic [4:0] OP_LOAD_D    = 5'd21;
  localparam logic [4:0] OP_PUBLISH   = 5'd22;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic near;
    logic far_reached;
    logic miss;
  } stat_t;

  typedef struct packed {
    logic [12:0]        frame_width;
    logic [12:0]        frame_height;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic [30:0]        focal_length;
    logic [30:0]        sphere_radius;
    logic [30:0]        far_depth;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        hit_depth;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } res_t;

  function automatic logic [31:0] mag32(input logic signed [32:0] v);
    logic [32:0] a;
    a = v[32] ? 33'(-v) : 33'(v);
    return a[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/stp_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Uses no package items.
module stp_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v, res, bitv, trial;
  logic [4:0]  cnt;
  logic        busy;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== rtl/stp_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses no package items.
module stp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] n;
  logic [32:0] rem, t;
  logic [5:0]  cnt;
  logic        busy;

  assign t   = {rem[31:0], n[63]};
  assign quo = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd63);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= num;
      rem <= '0;
    end else if (busy) begin
      if (t >= {1'b0, den}) begin
        rem <= t - {1'b0, den};
        n   <= {n[62:0], 1'b1};
      end else begin
        rem <= t;
        n   <= {n[62:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/stp_datapath.sv =====
// Datapath: ray, march and normal registers, shared product register, root and divide units.
// Depends on stp_pkg, stp_isqrt and stp_div.
module stp_datapath #(
  parameter int unsigned START_DEPTH = stp_pkg::START_DEF,
  parameter int unsigned HIT_EPSILON = stp_pkg::EPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  stp_pkg::cfg_t cfg,
  input  logic [11:0]   pixel_x,
  input  logic [11:0]   pixel_y,
  input  stp_pkg::cmd_t cmd,
  output stp_pkg::stat_t stat,
  output stp_pkg::res_t res
);

  localparam logic signed [35:0] EPS36 = 36'(HIT_EPSILON);
  localparam logic signed [33:0] EPS34 = 34'(HIT_EPSILON);

  logic signed [32:0] vec [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] pbase [3];
  logic signed [32:0] dv [3];
  logic signed [15:0] nrm [3];
  logic [63:0]        acc, prod;
  logic [31:0]        len, len_hi;
  logic signed [35:0] depth;
  logic               hit;

  logic [31:0]        msel, root, tmag;
  logic [30:0]        dmag;
  logic signed [31:0] dsel, eye_sel, pb;
  logic signed [33:0] tsig, psum, sdist;
  logic signed [13:0] dx, dy;
  logic [63:0]        quo, div_num;
  logic               sq_done, dv_done, neg;

  assign msel    = stp_pkg::mag32(vec[cmd.idx]);
  assign neg     = vec[cmd.idx][32];
  assign dsel    = dir[cmd.idx];
  assign dmag    = dsel[31] ? 31'(-dsel) : dsel[30:0];
  assign tmag    = prod[61:30];
  assign tsig    = dsel[31] ? -$signed({2'b00, tmag}) : $signed({2'b00, tmag});
  assign eye_sel = (cmd.idx == 2'd0) ? cfg.eye_x : (cmd.idx == 2'd1) ? cfg.eye_y : cfg.eye_z;
  assign psum    = {{2{eye_sel[31]}}, eye_sel} + tsig;
  assign pb      = pbase[cmd.idx];
  assign sdist   = $signed({2'b00, len}) - $signed({3'b000, cfg.sphere_radius});
  assign dx      = $signed({2'b00, pixel_x}) - $signed({2'b00, cfg.frame_width[12:1]});
  assign dy      = $signed({2'b00, pixel_y}) - $signed({2'b00, cfg.frame_height[12:1]});
  assign div_num = (cmd.op == stp_pkg::OP_DIV_DIR) ? (64'(msel) << 30) : (64'(msel) << 14);

  stp_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == stp_pkg::OP_SQRT),
    .value (acc),
    .done  (sq_done),
    .root  (root)
  );

  stp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start ((cmd.op == stp_pkg::OP_DIV_DIR) || (cmd.op == stp_pkg::OP_DIV_NRM)),
    .num   (div_num),
    .den   (len),
    .done  (dv_done),
    .quo   (quo)
  );

  always_comb begin
    stat.sqrt_done   = sq_done;
    stat.div_done    = dv_done;
    stat.near        = sdist < EPS34;
    stat.far_reached = depth >= $signed({5'b0, cfg.far_depth});
    stat.miss        = depth > ($signed({5'b0, cfg.far_depth}) - EPS36);
    res.hit          = hit;
    res.hit_depth    = hit ? depth[30:0] : 31'd0;
    res.normal_x     = hit ? nrm[0] : 16'sd0;
    res.normal_y     = hit ? nrm[1] : 16'sd0;
    res.normal_z     = hit ? nrm[2] : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (sq_done) len <= root;
    case (cmd.op)
      stp_pkg::OP_LOAD_RAY: begin
        vec[0] <= {{3{dx[13]}}, dx, 16'h0000};
        vec[1] <= {{3{dy[13]}}, dy, 16'h0000};
        vec[2] <= -$signed({2'b00, cfg.focal_length});
      end
      stp_pkg::OP_SQ_FIRST: begin
        prod <= msel * msel;
        acc  <= '0;
      end
      stp_pkg::OP_SQ: begin
        prod <= msel * msel;
        acc  <= acc + prod;
      end
      stp_pkg::OP_ACC: acc <= acc + prod;
      stp_pkg::OP_STORE_DIR:
        dir[cmd.idx] <= (len == 32'd0) ? 32'sd0 :
                        (neg ? -$signed(quo[31:0]) : $signed(quo[31:0]));
      stp_pkg::OP_STORE_NRM:
        nrm[cmd.idx] <= (len == 32'd0) ? 16'sd0 :
                        (neg ? -$signed(quo[15:0]) : $signed(quo[15:0]));
      stp_pkg::OP_INIT: depth <= 36'(START_DEPTH);
      stp_pkg::OP_MUL: prod <= 64'(dmag * depth[30:0]);
      stp_pkg::OP_PT: begin
        vec[cmd.idx]   <= 33'(stp_pkg::sat32(psum));
        pbase[cmd.idx] <= stp_pkg::sat32(psum);
      end
      stp_pkg::OP_STEP: if (!(sdist < EPS34)) depth <= depth + 36'(sdist);
      stp_pkg::OP_CLAMP: depth <= $signed({5'b0, cfg.far_depth});
      stp_pkg::OP_SET_MISS: hit <= 1'b0;
      stp_pkg::OP_SET_HIT: hit <= 1'b1;
      stp_pkg::OP_Q_HI, stp_pkg::OP_Q_LO: begin
        for (int j = 0; j < 3; j++)
          if (2'(j) != cmd.idx) vec[j] <= 33'(pbase[j]);
        if (cmd.op == stp_pkg::OP_Q_HI)
          vec[cmd.idx] <= 33'(stp_pkg::sat32({{2{pb[31]}}, pb} + EPS34));
        else
          vec[cmd.idx] <= 33'(stp_pkg::sat32({{2{pb[31]}}, pb} - EPS34));
      end
      stp_pkg::OP_SAVE_HI: len_hi <= len;
      stp_pkg::OP_SAVE_D: dv[cmd.idx] <= $signed({1'b0, len_hi}) - $signed({1'b0, len});
      stp_pkg::OP_LOAD_D: for (int j = 0; j < 3; j++) vec[j] <= dv[j];
      default: ;
    endcase
  end

endmodule

// ===== rtl/stp_ctrl.sv =====
// Controller: sequences ray setup, the march loop, the miss test and the normal.
// Depends on stp_pkg; drives stp_datapath through cmd_t and reads stat_t.
module stp_ctrl #(
  parameter int unsigned MAX_MARCH_STEPS = stp_pkg::MAX_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_free,
  input  stp_pkg::stat_t stat,
  output stp_pkg::cmd_t  cmd
);

  localparam int SW = $clog2(MAX_MARCH_STEPS + 1);
  localparam logic [SW-1:0] LAST_STEP = SW'(MAX_MARCH_STEPS - 1);

  localparam logic [3:0] ST_IDLE = 4'd0,  ST_SQ = 4'd1,    ST_ROOT = 4'd2,  ST_ROOTW = 4'd3;
  localparam logic [3:0] ST_POST = 4'd4,  ST_DIV = 4'd5,   ST_DIVW = 4'd6,  ST_DSTORE = 4'd7;
  localparam logic [3:0] ST_MINIT = 4'd8, ST_PT = 4'd9,    ST_CHK = 4'd10,  ST_MISS = 4'd11;
  localparam logic [3:0] ST_QHI = 4'd12,  ST_QLO = 4'd13,  ST_LOADD = 4'd14, ST_OUT = 4'd15;

  localparam logic [2:0] PH_RAY = 3'd0, PH_MARCH = 3'd1, PH_PNT = 3'd2;
  localparam logic [2:0] PH_HI = 3'd3,  PH_LO = 3'd4,    PH_D = 3'd5;

  logic [3:0]    state, state_next;
  logic [2:0]    sub, sub_next, ph, ph_next;
  logic [1:0]    k, k_next;
  logic [SW-1:0] step, step_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    sub_next   = sub;
    ph_next    = ph;
    k_next     = k;
    step_next  = step;
    cmd.op     = stp_pkg::OP_NOP;
    cmd.idx    = k;
    case (state)
      ST_IDLE: if (in_valid) begin
        cmd.op     = stp_pkg::OP_LOAD_RAY;
        ph_next    = PH_RAY;
        sub_next   = '0;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.idx  = sub[1:0];
        sub_next = sub + 3'd1;
        case (sub)
          3'd0: cmd.op = stp_pkg::OP_SQ_FIRST;
          3'd1, 3'd2: cmd.op = stp_pkg::OP_SQ;
          default: begin
            cmd.op     = stp_pkg::OP_ACC;
            cmd.idx    = 2'd0;
            state_next = ST_ROOT;
          end
        endcase
      end
      ST_ROOT: begin
        cmd.op     = stp_pkg::OP_SQRT;
        state_next = ST_ROOTW;
      end
      ST_ROOTW: if (stat.sqrt_done) state_next = ST_POST;
      ST_POST: begin
        case (ph)
          PH_MARCH: begin
            cmd.op     = stp_pkg::OP_STEP;
            state_next = stat.near ? ST_MISS : ST_CHK;
          end
          PH_HI: begin
            cmd.op     = stp_pkg::OP_SAVE_HI;
            state_next = ST_QLO;
          end
          PH_LO: begin
            cmd.op = stp_pkg::OP_SAVE_D;
            if (k == 2'd2) state_next = ST_LOADD;
            else begin
              k_next     = k + 2'd1;
              state_next = ST_QHI;
            end
          end
          default: begin
            k_next     = '0;
            state_next = ST_DIV;
          end
        endcase
      end
      ST_DIV: begin
        cmd.op     = (ph == PH_RAY) ? stp_pkg::OP_DIV_DIR : stp_pkg::OP_DIV_NRM;
        state_next = ST_DIVW;
      end
      ST_DIVW: if (stat.div_done) state_next = ST_DSTORE;
      ST_DSTORE: begin
        cmd.op = (ph == PH_RAY) ? stp_pkg::OP_STORE_DIR : stp_pkg::OP_STORE_NRM;
        if (k == 2'd2) state_next = (ph == PH_RAY) ? ST_MINIT : ST_OUT;
        else begin
          k_next     = k + 2'd1;
          state_next = ST_DIV;
        end
      end
      ST_MINIT: begin
        cmd.op     = stp_pkg::OP_INIT;
        step_next  = '0;
        ph_next    = PH_MARCH;
        sub_next   = '0;
        state_next = ST_PT;
      end
      ST_PT: begin
        cmd.op   = sub[0] ? stp_pkg::OP_PT : stp_pkg::OP_MUL;
        cmd.idx  = sub[2:1];
        sub_next = sub + 3'd1;
        if (sub == 3'd5) begin
          sub_next = '0;
          if (ph == PH_PNT) begin
            k_next     = '0;
            state_next = ST_QHI;
          end else begin
            state_next = ST_SQ;
          end
        end
      end
      ST_CHK: begin
        if (stat.far_reached || step == LAST_STEP) begin
          cmd.op     = stp_pkg::OP_CLAMP;
          state_next = ST_MISS;
        end else begin
          step_next  = step + 1'b1;
          sub_next   = '0;
          state_next = ST_PT;
        end
      end
      ST_MISS: begin
        if (stat.miss) begin
          cmd.op     = stp_pkg::OP_SET_MISS;
          state_next = ST_OUT;
        end else begin
          cmd.op     = stp_pkg::OP_SET_HIT;
          ph_next    = PH_PNT;
          sub_next   = '0;
          state_next = ST_PT;
        end
      end
      ST_QHI: begin
        cmd.op     = stp_pkg::OP_Q_HI;
        ph_next    = PH_HI;
        sub_next   = '0;
        state_next = ST_SQ;
      end
      ST_QLO: begin
        cmd.op     = stp_pkg::OP_Q_LO;
        ph_next    = PH_LO;
        sub_next   = '0;
        state_next = ST_SQ;
      end
      ST_LOADD: begin
        cmd.op     = stp_pkg::OP_LOAD_D;
        ph_next    = PH_D;
        sub_next   = '0;
        state_next = ST_SQ;
      end
      ST_OUT: if (out_free) begin
        cmd.op     = stp_pkg::OP_PUBLISH;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sub   <= '0;
      ph    <= PH_RAY;
      k     <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      sub   <= sub_next;
      ph    <= ph_next;
      k     <= k_next;
      step  <= step_next;
    end
  end

endmodule

// ===== rtl/sphere_trace_pixel.sv =====
// Top level of the sphere-trace pixel block: registers, output stage, controller, datapath.
// Depends on stp_pkg, stp_ctrl and stp_datapath.
//
//   channel  direction  request carries
//   s_*      in         pixel_x, pixel_y
//   m_*      out        hit (tuser), hit_depth and normal (tdata)
//   cfg_*    in         register index and write data
//
// One pixel at a time. Each vector length squares and accumulates the three
// components and then takes the square root; each divide divides one component
// by that length, and the normal is computed only for a hit. Reset is synchronous;
// a finished result waits in the output register while the next pixel is taken.
// cfg writes are always accepted.
module sphere_trace_pixel #(
  parameter int unsigned MAX_MARCH_STEPS = stp_pkg::MAX_STEPS_DEF,
  parameter int unsigned START_DEPTH     = stp_pkg::START_DEF,
  parameter int unsigned HIT_EPSILON     = stp_pkg::EPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pixel_x[11:0], pixel_y[23:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // hit_depth[30:0], normal_x[46:31], normal_y[62:47],
                                 // normal_z[78:63], zero[79]
  output logic [0:0]  m_tuser,   // hit[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  stp_pkg::cfg_t  cfg;
  stp_pkg::cmd_t  cmd;
  stp_pkg::stat_t stat;
  stp_pkg::res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= 13'd640;
      cfg.frame_height  <= 13'd480;
      cfg.eye_x         <= 32'sd0;
      cfg.eye_y         <= 32'sd0;
      cfg.eye_z         <= 32'sd1310720;
      cfg.focal_length  <= 31'd27197439;
      cfg.sphere_radius <= 31'd327680;
      cfg.far_depth     <= 31'd6553600;
    end else if (cfg_valid) begin
      case (cfg_index)
        stp_pkg::REG_FRAME_W: cfg.frame_width   <= cfg_data[12:0];
        stp_pkg::REG_FRAME_H: cfg.frame_height  <= cfg_data[12:0];
        stp_pkg::REG_EYE_X:   cfg.eye_x         <= cfg_data;
        stp_pkg::REG_EYE_Y:   cfg.eye_y         <= cfg_data;
        stp_pkg::REG_EYE_Z:   cfg.eye_z         <= cfg_data;
        stp_pkg::REG_FOCAL:   cfg.focal_length  <= cfg_data[30:0];
        stp_pkg::REG_RADIUS:  cfg.sphere_radius <= cfg_data[30:0];
        stp_pkg::REG_FAR:     cfg.far_depth     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  stp_ctrl #(
    .MAX_MARCH_STEPS (MAX_MARCH_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (!m_tvalid || m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stp_datapath #(
    .START_DEPTH (START_DEPTH),
    .HIT_EPSILON (HIT_EPSILON)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pixel_x (s_tdata[11:0]),
    .pixel_y (s_tdata[23:12]),
    .cmd     (cmd),
    .stat    (stat),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == stp_pkg::OP_PUBLISH) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == stp_pkg::OP_PUBLISH) begin
      m_tdata <= {1'b0, res.normal_z, res.normal_y, res.normal_x, res.hit_depth};
      m_tuser <= res.hit;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a pixel is in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 80'd0))
    else $error("miss result carries nonzero fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == stp_pkg::OP_PUBLISH) |-> (!m_tvalid || m_tready))
    else $error("result published over a waiting result");

  a_publish_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == stp_pkg::OP_PUBLISH) |-> !s_tready)
    else $error("publish while idle");

endmodule

// ===== verif/sphere_trace_pixel_tb.sv =====
// Testbench for sphere_trace_pixel: streams pixels and checks hit, depth and normal
// against an in-bench integer ray marcher, under random stalls and config changes.
// Depends on stp_pkg and the sphere_trace_pixel RTL.
module sphere_trace_pixel_tb;

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint NEG_MIN = -64'sd2147483648;
  localparam longint EPS = stp_pkg::EPS_DEF;
  localparam int unsigned CYCLE_LIMIT = 40_000_000;

  class trace_scoreboard;
    longint fw, fh, ex, ey, ez, focal, radius, far_d;
    stp_pkg::res_t pending_q[$];
    int errors, checked, hits;

    function new();
      fw = 640; fh = 480; ex = 0; ey = 0; ez = 1310720;
      focal = 27197439; radius = 327680; far_d = 6553600;
    endfunction

    function void set_reg(logic [3:0] idx, logic [31:0] v);
      case (idx)
        stp_pkg::REG_FRAME_W: fw = v[12:0];
        stp_pkg::REG_FRAME_H: fh = v[12:0];
        stp_pkg::REG_EYE_X:   ex = longint'($signed(v));
        stp_pkg::REG_EYE_Y:   ey = longint'($signed(v));
        stp_pkg::REG_EYE_Z:   ez = longint'($signed(v));
        stp_pkg::REG_FOCAL:   focal = v[30:0];
        stp_pkg::REG_RADIUS:  radius = v[30:0];
        stp_pkg::REG_FAR:     far_d = v[30:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned absval(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint signed_of(longint unsigned m, bit neg);
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint clamp32(longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < NEG_MIN) return NEG_MIN;
      return v;
    endfunction

    function longint unsigned length3(longint a, longint b, longint c);
      longint unsigned x = absval(a), y = absval(b), z = absval(c);
      return root64(x * x + y * y + z * z);
    endfunction

    function longint sdf(longint a, longint b, longint c);
      return longint'(length3(a, b, c)) - radius;
    endfunction

    function longint frac_div(longint num, longint unsigned scale, longint unsigned den);
      return signed_of(absval(num) * scale / den, num < 0);
    endfunction

    function longint along(longint dir, longint depth);
      return signed_of((absval(dir) * absval(depth)) >> 30, dir < 0);
    endfunction

    function stp_pkg::res_t trace(logic [11:0] px, logic [11:0] py);
      longint ray[3], dir[3], p[3], q[3], d[3];
      longint depth, step_dist, hi, lo;
      longint unsigned m;
      int i;
      stp_pkg::res_t r;
      r = '0;
      ray[0] = (longint'(px) - (fw >> 1)) * 65536;
      ray[1] = (longint'(py) - (fh >> 1)) * 65536;
      ray[2] = -focal;
      m = length3(ray[0], ray[1], ray[2]);
      for (int k = 0; k < 3; k++) dir[k] = (m == 0) ? 0 : frac_div(ray[k], 64'd1 << 30, m);
      depth = stp_pkg::START_DEF;
      for (i = 0; i < stp_pkg::MAX_STEPS_DEF; i++) begin
        p[0] = clamp32(ex + along(dir[0], depth));
        p[1] = clamp32(ey + along(dir[1], depth));
        p[2] = clamp32(ez + along(dir[2], depth));
        step_dist = sdf(p[0], p[1], p[2]);
        if (step_dist < EPS) break;
        depth += step_dist;
        if (depth >= far_d) begin
          depth = far_d;
          break;
        end
      end
      if (i == stp_pkg::MAX_STEPS_DEF) depth = far_d;
      if (depth > far_d - EPS) return r;
      p[0] = clamp32(ex + along(dir[0], depth));
      p[1] = clamp32(ey + along(dir[1], depth));
      p[2] = clamp32(ez + along(dir[2], depth));
      for (int k = 0; k < 3; k++) begin
        q = p;
        q[k] = clamp32(p[k] + EPS);
        hi = sdf(q[0], q[1], q[2]);
        q[k] = clamp32(p[k] - EPS);
        lo = sdf(q[0], q[1], q[2]);
        d[k] = hi - lo;
      end
      m = length3(d[0], d[1], d[2]);
      r.hit = 1'b1;
      r.hit_depth = depth[30:0];
      if (m != 0) begin
        r.normal_x = 16'(frac_div(d[0], 16384, m));
        r.normal_y = 16'(frac_div(d[1], 16384, m));
        r.normal_z = 16'(frac_div(d[2], 16384, m));
      end
      return r;
    endfunction

    function void note_pixel(logic [11:0] px, logic [11:0] py);
      pending_q.push_back(trace(px, py));
    endfunction

    function void check_result(stp_pkg::res_t got);
      stp_pkg::res_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      checked++;
      if (exp_r.hit) hits++;
      if (got.hit !== exp_r.hit) begin
        $error("hit: expected %0d got %0d", exp_r.hit, got.hit); errors++;
      end
      if (got.hit_depth !== exp_r.hit_depth) begin
        $error("hit_depth: expected %0d got %0d", exp_r.hit_depth, got.hit_depth); errors++;
      end
      if (got.normal_x !== exp_r.normal_x) begin
        $error("normal_x: expected %0d got %0d", exp_r.normal_x, got.normal_x); errors++;
      end
      if (got.normal_y !== exp_r.normal_y) begin
        $error("normal_y: expected %0d got %0d", exp_r.normal_y, got.normal_y); errors++;
      end
      if (got.normal_z !== exp_r.normal_z) begin
        $error("normal_z: expected %0d got %0d", exp_r.normal_z, got.normal_z); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  trace_scoreboard sb = new();
  int unsigned cycles = 0;
  int burst_left = 0;
  int ready_run = 0;
  int sent = 0;

  sphere_trace_pixel uut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sphere_trace_pixel_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_run == 0) begin
      m_tready <= ($urandom_range(0, 2) != 0);
      ready_run <= $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(20, 300);
    end else ready_run <= ready_run - 1;
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready)
      sb.check_result({m_tuser[0], m_tdata[30:0], m_tdata[46:31], m_tdata[62:47],
                       m_tdata[78:63]});

  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    if (burst_left == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1;
    s_tdata <= {py, px};
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(px, py);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic scene(int w, int h, int eyx, int eyy, int eyz, int f, int rad, int fd);
    drain();
    write_reg(stp_pkg::REG_FRAME_W, w);
    write_reg(stp_pkg::REG_FRAME_H, h);
    write_reg(stp_pkg::REG_EYE_X, eyx);
    write_reg(stp_pkg::REG_EYE_Y, eyy);
    write_reg(stp_pkg::REG_EYE_Z, eyz);
    write_reg(stp_pkg::REG_FOCAL, f);
    write_reg(stp_pkg::REG_RADIUS, rad);
    write_reg(stp_pkg::REG_FAR, fd);
  endtask

  initial begin
    int w, h;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // default scene: center hit, corners miss
    send_pixel(320, 240);
    send_pixel(330, 250);
    send_pixel(0, 0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'hfff, 0);
    send_pixel(0, 12'hfff);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);

    // zero ray at the center, eye outside the sphere
    scene(640, 480, 0, 0, 20 << 16, 0, 5 << 16, 100 << 16);
    send_pixel(320, 240);
    send_pixel(321, 240);
    // eye at the sphere center: hit at depth zero, flat gradient
    scene(640, 480, 0, 0, 0, 0, 5 << 16, 100 << 16);
    send_pixel(320, 240);
    send_pixel(0, 4095);
    // frame size extremes, ignored index, saturated eye, zero and max radius/far
    scene(0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h7fff_ffff, 0, 32'hffff_ffff);
    write_reg(4'd9, 32'h1234_5678);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    scene(8191, 1, 32'h8000_0000, 0, 0, 1, 32'h7fff_ffff, 0);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    scene(4096, 4096, 0, 0, 40 << 16, 4096 << 16, 2 << 16, 32'h7fff_ffff);
    send_pixel(2048, 2048);
    send_pixel(2050, 2047);

    // random scenes, mostly camera looking at the sphere
    for (int ph = 0; ph < 6; ph++) begin
      w = $urandom_range(8, 200);
      h = $urandom_range(8, 200);
      scene(w, h, $urandom_range(0, 4 << 16) - (2 << 16), $urandom_range(0, 4 << 16) - (2 << 16),
            $urandom_range(10 << 16, 40 << 16), h * $urandom_range(1 << 16, 4 << 16) / 2,
            $urandom_range(2 << 16, 10 << 16), $urandom_range(60 << 16, 150 << 16));
      for (int n = 0; n < 45; n++)
        if ($urandom_range(0, 9) == 0) send_pixel(12'($urandom), 12'($urandom));
        else send_pixel(12'($urandom_range(0, w)), 12'($urandom_range(0, h)));
    end

    drain();
    repeat (100) @(posedge clk);
    $display("%0d pixels sent, %0d results checked, %0d hits, through directed and random scenes",
             sent, sb.checked, sb.hits);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("sphere_trace_pixel_tb passed");
    else $display("sphere_trace_pixel_tb failed");
    $finish;
  end
endmodule
